FILE: rtl/blt_pkg.sv
// Shared types and constants for the binary lane tracker.
package blt_pkg;

    typedef struct packed {
        logic [31:0] pixel_bits;
        logic        frame_end;
    } item_t;

    typedef struct packed {
        logic               found;
        logic signed [11:0] steering_milli;
    } result_t;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_RANGE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STEP         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTH_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_THRESHOLD = 3'd4;

    localparam logic [6:0]  RST_POINT_COUNT      = 7'd25;
    localparam logic [7:0]  RST_SEARCH_RANGE     = 8'd40;
    localparam logic [4:0]  RST_ROW_STEP         = 5'd5;
    localparam logic [15:0] RST_SMOOTH_LIMIT     = 16'd15;
    localparam logic [6:0]  RST_COLUMN_THRESHOLD = 7'd19;

    localparam int START_ROW   = 500;
    localparam int SUM_ROWS    = 64;
    localparam int BAND_MARGIN = 128;
    localparam int NEEDED_MIDS = 5;
    localparam int CNT_W       = 7;
    localparam int ACC_W       = 6;
    localparam int ROW_W       = 12;
    localparam int MID_CNT_W   = 3;

    localparam logic [1:0] PH_RIGHT_START = 2'd0;
    localparam logic [1:0] PH_LEFT_START  = 2'd1;
    localparam logic [1:0] PH_TRACK_LEFT  = 2'd2;
    localparam logic [1:0] PH_TRACK_RIGHT = 2'd3;

    typedef struct packed {
        logic       store;
        logic       init;
        logic       prep;
        logic       div;
        logic       base;
        logic       issue;
        logic       acc;
        logic       advance;
        logic       take;
        logic       miss;
        logic       commit;
        logic       fin_sq;
        logic       fin_acc;
        logic       next_k;
        logic       emit;
        logic [1:0] phase;
    } blt_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic last_word;
        logic acc_last;
        logic more_points;
        logic has_prev;
    } blt_status_t;

endpackage

FILE: rtl/binary_lane_tracker_unit.sv
// Top level of the binary lane tracker: sequencer plus datapath.
// Load: one frame word per cycle while busy is low; only the frame_end word raises busy.
// After frame_end: the start search sums column counts word by word per side, then each
// sample row scans its window words for each lane (one store read port).
// A smoothing tail follows, then done strobes for one cycle; the receiver cannot stall it.
// Reset clears sequencer, write pointer, config and done; store and other state are unset.
module binary_lane_tracker_unit #(
    parameter int FRAME_WIDTH  = 768,
    parameter int FRAME_HEIGHT = 512,
    parameter int MAX_POINTS   = 64,
    parameter int WORD_PIXELS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  blt_pkg::item_t                   item,
    output logic                             done,
    output blt_pkg::result_t                 result,
    input  logic                             cfg_write,
    input  logic [blt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import blt_pkg::*;

    blt_cmd_t    cmd;
    blt_status_t status;

    blt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .frame_end (item.frame_end),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    blt_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .MAX_POINTS   (MAX_POINTS),
        .WORD_PIXELS  (WORD_PIXELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

FILE: rtl/blt_ram.sv
// Generic single-port-write, registered-read RAM.
module blt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12288,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/blt_ctrl.sv
// Sequencer for frame load, start search, lane tracking and result output.
module blt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                frame_end,
    input  blt_pkg::blt_status_t status,
    output blt_pkg::blt_cmd_t   cmd,
    output logic                busy
);
    import blt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_BASE   = 4'd3;
    localparam logic [3:0] S_ISSUE  = 4'd4;
    localparam logic [3:0] S_ACC    = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_TEST   = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_LOOP   = 4'd9;
    localparam logic [3:0] S_COMMIT = 4'd10;
    localparam logic [3:0] S_FINSQ  = 4'd11;
    localparam logic [3:0] S_FINACC = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       count_mode;

    assign count_mode = (phase_reg == PH_RIGHT_START) || (phase_reg == PH_LEFT_START);
    assign busy       = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.phase  = phase_reg;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.store = 1'b1;
                    if (frame_end)
                    begin
                        cmd.init   = 1'b1;
                        phase_next = PH_RIGHT_START;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.empty)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.div    = 1'b1;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = count_mode ? S_ACC : S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_TEST;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.acc_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (status.hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_NEXT;
                end
                else if (status.last_word)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = count_mode ? S_ACC : S_ISSUE;
                end
            end
            S_NEXT:
            begin
                unique case (phase_reg)
                    PH_RIGHT_START:
                    begin
                        phase_next = PH_LEFT_START;
                        state_next = S_PREP;
                    end
                    PH_LEFT_START:
                    begin
                        state_next = S_LOOP;
                    end
                    PH_TRACK_LEFT:
                    begin
                        phase_next = PH_TRACK_RIGHT;
                        state_next = S_PREP;
                    end
                    PH_TRACK_RIGHT:
                    begin
                        state_next = S_COMMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOOP:
            begin
                if (status.more_points)
                begin
                    phase_next = PH_TRACK_LEFT;
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (status.has_prev)
                begin
                    state_next = S_FINSQ;
                end
                else if (status.more_points)
                begin
                    cmd.next_k = 1'b1;
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_FINSQ:
            begin
                cmd.fin_sq = 1'b1;
                state_next = S_FINACC;
            end
            S_FINACC:
            begin
                cmd.fin_acc = 1'b1;
                if (status.more_points)
                begin
                    cmd.next_k = 1'b1;
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_RIGHT_START;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: rtl/blt_datapath.sv
// Frame store, column counters, window scan, smoothing and steering sum.
module blt_datapath #(
    parameter int FRAME_WIDTH  = 768,
    parameter int FRAME_HEIGHT = 512,
    parameter int MAX_POINTS   = 64,
    parameter int WORD_PIXELS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [blt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  blt_pkg::item_t                      item,
    input  blt_pkg::blt_cmd_t                   cmd,
    output blt_pkg::blt_status_t                status,
    output logic                                done,
    output blt_pkg::result_t                    result
);
    import blt_pkg::*;

    localparam int ROW_WORDS   = (FRAME_WIDTH + WORD_PIXELS - 1) / WORD_PIXELS;
    localparam int STORE_DEPTH = ROW_WORDS * FRAME_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int PW          = $clog2(STORE_DEPTH + 1);
    localparam int COL_W       = $clog2(FRAME_WIDTH);
    localparam int SW          = COL_W + 2;
    localparam int WW          = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int LW          = (WORD_PIXELS > 1) ? $clog2(WORD_PIXELS) : 1;
    localparam int KW          = $clog2(MAX_POINTS + 1);
    localparam int MID_COL     = FRAME_WIDTH / 2;
    localparam int BAND_LO     = BAND_MARGIN;
    localparam int BAND_HI     = FRAME_WIDTH - BAND_MARGIN;
    localparam int CNT_BASE    = (FRAME_HEIGHT - SUM_ROWS) * ROW_WORDS;
    localparam int DIV_L       = $clog2(WORD_PIXELS);
    localparam int DIV_S       = COL_W + DIV_L;
    localparam int DIV_M       = ((1 << DIV_S) + WORD_PIXELS - 1) / WORD_PIXELS;
    localparam int PROD_W      = COL_W + DIV_S + 1;
    localparam int D_W         = COL_W + 3;
    localparam int SQ_W        = 2 * D_W;
    localparam int SUM_W       = $clog2(NEEDED_MIDS * FRAME_WIDTH);
    localparam int DIFF_W      = (SUM_W + 1 > 12) ? SUM_W + 1 : 12;
    localparam int STEER_BASE  = NEEDED_MIDS * MID_COL;

    // configuration
    logic [6:0]  pc_reg;
    logic [7:0]  rng_reg;
    logic [4:0]  step_reg;
    logic [15:0] lim_reg;
    logic [6:0]  thr_reg;

    // frame store
    logic [PW-1:0]          wp_reg;
    logic                   ram_we;
    logic [63:0]            wide_word;
    logic [WORD_PIXELS-1:0] ram_wdata;
    logic [WORD_PIXELS-1:0] rdata;
    logic                   ram_re;

    // scan engine
    logic                   count_mode, dir_desc;
    logic [COL_W-1:0]       lo_reg, hi_reg;
    logic                   empty_reg;
    logic [AW-1:0]          base_reg, addr_reg, row_base;
    logic [WW-1:0]          w_reg, wend_reg, w_step;
    logic [COL_W-1:0]       wbase_reg, wbase_step;
    logic [ACC_W-1:0]       acc_cnt_reg;
    logic                   acc_vld_reg;
    logic [CNT_W-1:0]       counts_reg [WORD_PIXELS];
    logic signed [SW-1:0]   s_l, s_r, r_ext, win_lo, win_hi, lo_c, hi_c;
    logic                   win_empty;
    logic [WORD_PIXELS-1:0] cand;
    logic [LW-1:0]          hit_idx;
    logic                   hit_any;
    logic [COL_W-1:0]       hit_col;

    // tracking
    logic [COL_W-1:0]         sl_reg, sr_reg;
    logic signed [ROW_W-1:0]  row_reg;
    logic [KW-1:0]            k_reg, n_val;
    logic [COL_W-1:0]         new_l_reg, new_r_reg;
    logic                     new_lt_reg, new_rt_reg;
    logic [COL_W-1:0]         pl_reg [3];
    logic [COL_W-1:0]         pr_reg [3];
    logic                     tl_reg [3];
    logic                     tr_reg [3];
    logic [SQ_W-1:0]          sq_l_reg, sq_r_reg;
    logic                     test_reg;
    logic [MID_CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [D_W-1:0]    d_l, d_r;
    logic                     keep_l, keep_r;
    logic [COL_W:0]           mid_sum;
    logic [DIFF_W-1:0]        diff;
    logic                     done_reg;
    result_t                  result_reg;

    function automatic logic [WW-1:0] word_of(input logic [COL_W-1:0] c);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(c) * PROD_W'(DIV_M);
        return WW'(prod >> DIV_S);
    endfunction

    assign count_mode = (cmd.phase == PH_RIGHT_START) || (cmd.phase == PH_LEFT_START);
    assign dir_desc   = (cmd.phase == PH_LEFT_START) || (cmd.phase == PH_TRACK_LEFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= RST_POINT_COUNT;
            rng_reg  <= RST_SEARCH_RANGE;
            step_reg <= RST_ROW_STEP;
            lim_reg  <= RST_SMOOTH_LIMIT;
            thr_reg  <= RST_COLUMN_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POINT_COUNT:      pc_reg   <= cfg_data[6:0];
                CFG_SEARCH_RANGE:     rng_reg  <= cfg_data[7:0];
                CFG_ROW_STEP:         step_reg <= cfg_data[4:0];
                CFG_SMOOTH_LIMIT:     lim_reg  <= cfg_data[15:0];
                CFG_COLUMN_THRESHOLD: thr_reg  <= cfg_data[6:0];
                default:              ;
            endcase
        end
    end

    // frame store: words past the end are dropped
    assign wide_word = {32'd0, item.pixel_bits};
    assign ram_wdata = wide_word[WORD_PIXELS-1:0];
    assign ram_we    = cmd.store && (wp_reg < PW'(STORE_DEPTH));
    assign ram_re    = cmd.issue || cmd.acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else if (cmd.store)
        begin
            if (item.frame_end)
            begin
                wp_reg <= '0;
            end
            else if (wp_reg < PW'(STORE_DEPTH))
            begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    blt_ram #(
        .WIDTH (WORD_PIXELS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // search window for the current phase
    always_comb
    begin
        s_l   = $signed({2'b00, sl_reg});
        s_r   = $signed({2'b00, sr_reg});
        r_ext = $signed(SW'(rng_reg));
        unique case (cmd.phase)
            PH_RIGHT_START:
            begin
                win_lo = $signed(SW'(MID_COL));
                win_hi = $signed(SW'(BAND_HI - 1));
            end
            PH_LEFT_START:
            begin
                win_lo = $signed(SW'(BAND_LO + 1));
                win_hi = $signed(SW'(MID_COL - 1));
            end
            PH_TRACK_LEFT:
            begin
                win_lo = s_l - r_ext + $signed(SW'(1));
                win_hi = s_l + r_ext;
            end
            PH_TRACK_RIGHT:
            begin
                win_lo = s_r - r_ext;
                win_hi = s_r + r_ext - $signed(SW'(1));
            end
            default:
            begin
                win_lo = '0;
                win_hi = '0;
            end
        endcase
        lo_c = (win_lo < $signed(SW'(0))) ? $signed(SW'(0)) : win_lo;
        hi_c = (win_hi > $signed(SW'(FRAME_WIDTH - 1))) ? $signed(SW'(FRAME_WIDTH - 1)) : win_hi;
        win_empty = (win_lo > win_hi) || (win_hi < $signed(SW'(0)))
                 || (win_lo > $signed(SW'(FRAME_WIDTH - 1)))
                 || (!count_mode && (row_reg < $signed(ROW_W'(0))));
    end

    assign row_base   = AW'(AW'(row_reg[ROW_W-2:0]) * AW'(ROW_WORDS));
    assign w_step     = dir_desc ? (w_reg - 1'b1) : (w_reg + 1'b1);
    assign wbase_step = dir_desc ? (wbase_reg - COL_W'(WORD_PIXELS))
                                 : (wbase_reg + COL_W'(WORD_PIXELS));

    // qualifying columns of the current word, nearest first
    always_comb
    begin
        logic [COL_W:0] col_b;
        hit_idx = '0;
        for (int b = 0; b < WORD_PIXELS; b++)
        begin
            col_b   = (COL_W+1)'(wbase_reg) + (COL_W+1)'(b);
            cand[b] = (col_b >= (COL_W+1)'(lo_reg)) && (col_b <= (COL_W+1)'(hi_reg))
                   && (count_mode ? (counts_reg[b] > thr_reg) : rdata[b]);
        end
        if (dir_desc)
        begin
            for (int b = 0; b < WORD_PIXELS; b++)
            begin
                if (cand[b])
                begin
                    hit_idx = LW'(b);
                end
            end
        end
        else
        begin
            for (int b = WORD_PIXELS - 1; b >= 0; b--)
            begin
                if (cand[b])
                begin
                    hit_idx = LW'(b);
                end
            end
        end
        hit_any = |cand;
        hit_col = wbase_reg + COL_W'(hit_idx);
    end

    assign n_val = (pc_reg > 7'(MAX_POINTS)) ? KW'(MAX_POINTS) : pc_reg[KW-1:0];

    always_comb
    begin
        d_l = $signed(D_W'(pl_reg[0])) + $signed(D_W'(pl_reg[2]))
            - $signed(D_W'({pl_reg[1], 1'b0}));
        d_r = $signed(D_W'(pr_reg[0])) + $signed(D_W'(pr_reg[2]))
            - $signed(D_W'({pr_reg[1], 1'b0}));
        keep_l  = tl_reg[1] && (!test_reg || (sq_l_reg < SQ_W'({lim_reg, 2'b00})));
        keep_r  = tr_reg[1] && (!test_reg || (sq_r_reg < SQ_W'({lim_reg, 2'b00})));
        mid_sum = (COL_W+1)'(pl_reg[1]) + (COL_W+1)'(pr_reg[1]);
        diff    = DIFF_W'(STEER_BASE) - DIFF_W'(sum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= cmd.acc;
            done_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            lo_reg    <= lo_c[COL_W-1:0];
            hi_reg    <= hi_c[COL_W-1:0];
            empty_reg <= win_empty;
            base_reg  <= count_mode ? AW'(CNT_BASE) : row_base;
        end
        if (cmd.div)
        begin
            w_reg    <= word_of(dir_desc ? hi_reg : lo_reg);
            wend_reg <= word_of(dir_desc ? lo_reg : hi_reg);
        end
        if (cmd.base)
        begin
            wbase_reg   <= COL_W'(COL_W'(w_reg) * COL_W'(WORD_PIXELS));
            addr_reg    <= base_reg + AW'(w_reg);
            acc_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            w_reg       <= w_step;
            wbase_reg   <= wbase_step;
            addr_reg    <= base_reg + AW'(w_step);
            acc_cnt_reg <= '0;
        end
        else if (cmd.acc)
        begin
            addr_reg    <= addr_reg + AW'(ROW_WORDS);
            acc_cnt_reg <= acc_cnt_reg + 1'b1;
        end
        for (int b = 0; b < WORD_PIXELS; b++)
        begin
            if (cmd.base || cmd.advance)
            begin
                counts_reg[b] <= '0;
            end
            else if (acc_vld_reg)
            begin
                counts_reg[b] <= counts_reg[b] + CNT_W'(rdata[b]);
            end
        end

        if (cmd.init)
        begin
            sl_reg  <= COL_W'(BAND_LO);
            sr_reg  <= COL_W'(BAND_HI);
            row_reg <= ROW_W'(START_ROW);
            k_reg   <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.take)
        begin
            unique case (cmd.phase)
                PH_RIGHT_START: sr_reg <= hit_col;
                PH_LEFT_START:  sl_reg <= hit_col;
                PH_TRACK_LEFT:
                begin
                    sl_reg     <= hit_col;
                    new_l_reg  <= hit_col;
                    new_lt_reg <= 1'b1;
                end
                PH_TRACK_RIGHT:
                begin
                    sr_reg     <= hit_col;
                    new_r_reg  <= hit_col;
                    new_rt_reg <= 1'b1;
                end
                default: ;
            endcase
        end
        if (cmd.miss)
        begin
            unique case (cmd.phase)
                PH_TRACK_LEFT:
                begin
                    new_l_reg  <= '0;
                    new_lt_reg <= 1'b0;
                end
                PH_TRACK_RIGHT:
                begin
                    new_r_reg  <= '0;
                    new_rt_reg <= 1'b0;
                end
                default: ;
            endcase
        end
        if (cmd.commit)
        begin
            pl_reg[0] <= pl_reg[1];
            pl_reg[1] <= pl_reg[2];
            pl_reg[2] <= new_l_reg;
            tl_reg[0] <= tl_reg[1];
            tl_reg[1] <= tl_reg[2];
            tl_reg[2] <= new_lt_reg;
            pr_reg[0] <= pr_reg[1];
            pr_reg[1] <= pr_reg[2];
            pr_reg[2] <= new_r_reg;
            tr_reg[0] <= tr_reg[1];
            tr_reg[1] <= tr_reg[2];
            tr_reg[2] <= new_rt_reg;
        end
        if (cmd.fin_sq)
        begin
            sq_l_reg <= SQ_W'(d_l * d_l);
            sq_r_reg <= SQ_W'(d_r * d_r);
            // end points of the sample run are never tested
            test_reg <= (k_reg >= KW'(2)) && (k_reg < n_val);
        end
        if (cmd.fin_acc && (cnt_reg < MID_CNT_W'(NEEDED_MIDS)) && keep_l && keep_r)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(mid_sum[COL_W:1]);
        end
        if (cmd.next_k)
        begin
            k_reg   <= k_reg + 1'b1;
            row_reg <= row_reg - $signed(ROW_W'(step_reg));
        end
        if (cmd.emit)
        begin
            result_reg.found          <= (cnt_reg >= MID_CNT_W'(NEEDED_MIDS));
            result_reg.steering_milli <= (cnt_reg >= MID_CNT_W'(NEEDED_MIDS))
                                         ? $signed(diff[11:0]) : 12'sd0;
        end
    end

    assign status.empty       = empty_reg;
    assign status.hit         = hit_any;
    assign status.last_word   = (w_reg == wend_reg);
    assign status.acc_last    = (acc_cnt_reg == ACC_W'(SUM_ROWS - 1));
    assign status.more_points = (k_reg < n_val);
    assign status.has_prev    = (k_reg != '0);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/blt_checker.sv
// Port-level checks for the binary lane tracker, bound to the top level.
module blt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input blt_pkg::item_t   item,
    input logic             done,
    input blt_pkg::result_t result
);
    import blt_pkg::*;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without evaluation");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_idle_steer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.steering_milli == 12'sd0))
        else $error("steering set without lane");

    a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.frame_end) |=> (busy && !done))
        else $error("frame end did not start evaluation");

endmodule

bind binary_lane_tracker_unit blt_checker u_blt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

FILE: bench/testbench.sv
// Self-checking bench for binary_lane_tracker_unit: frame loads, lane images, register sweeps.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import blt_pkg::*;

    localparam int WIDTH       = 768;
    localparam int HEIGHT      = 512;
    localparam int ROW_WORDS   = WIDTH / 32;
    localparam int STORE_WORDS = ROW_WORDS * HEIGHT;
    localparam int MID         = WIDTH / 2;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    item_t                  beat = '0;
    logic                   done;
    result_t                result;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_POINT_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [31:0] frame_mem [STORE_WORDS];
    int          load_ptr = 0;
    int          points_reg = RST_POINT_COUNT;
    int          range_reg = RST_SEARCH_RANGE;
    int          step_reg = RST_ROW_STEP;
    int          smooth_reg = RST_SMOOTH_LIMIT;
    int          thresh_reg = RST_COLUMN_THRESHOLD;
    result_t     pending_results [$];
    int          gap_pct = 0;
    int          errors = 0;

    binary_lane_tracker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (beat),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit pixel_at(int r, int c);
        if (r < 0 || r >= HEIGHT || c < 0 || c >= WIDTH)
            return 1'b0;
        return frame_mem[r * ROW_WORDS + c / 32][c % 32];
    endfunction

    function automatic void drop_rough(ref int cols[64], ref bit trust[64], input int n);
        longint d;
        for (int i = 1; i + 1 < n; i++)
        begin
            d = longint'(cols[i-1]) + cols[i+1] - 2 * cols[i];
            trust[i] = trust[i] && (d * d < 4 * longint'(smooth_reg));
        end
    endfunction

    function automatic result_t track_lanes();
        int      n, rng, ls, rs, row, cnt, sum;
        int      colsum [WIDTH];
        int      lcol [64];
        int      rcol [64];
        bit      lt [64];
        bit      rt [64];
        logic [31:0] v;
        result_t res;
        n = points_reg > 64 ? 64 : points_reg;
        rng = range_reg;
        ls = BAND_MARGIN;
        rs = WIDTH - BAND_MARGIN;
        for (int c = BAND_MARGIN; c < WIDTH - BAND_MARGIN; c++)
        begin
            colsum[c] = 0;
            for (int r = HEIGHT - SUM_ROWS; r < HEIGHT; r++)
                colsum[c] += pixel_at(r, c);
        end
        for (int c = MID; c < WIDTH - BAND_MARGIN; c++)
            if (colsum[c] > thresh_reg)
            begin
                rs = c;
                break;
            end
        for (int c = MID - 1; c > BAND_MARGIN; c--)
            if (colsum[c] > thresh_reg)
            begin
                ls = c;
                break;
            end
        for (int k = 0; k < 64; k++)
        begin
            lcol[k] = 0; rcol[k] = 0; lt[k] = 0; rt[k] = 0;
        end
        row = START_ROW;
        for (int k = 0; k < n; k++)
        begin
            for (int c = ls + rng; c > ls - rng; c--)
                if (pixel_at(row, c))
                begin
                    lcol[k] = c; lt[k] = 1; ls = c;
                    break;
                end
            for (int c = rs - rng; c < rs + rng; c++)
                if (pixel_at(row, c))
                begin
                    rcol[k] = c; rt[k] = 1; rs = c;
                    break;
                end
            row -= step_reg;
        end
        drop_rough(lcol, lt, n);
        drop_rough(rcol, rt, n);
        cnt = 0;
        sum = 0;
        for (int k = 0; k < n && cnt < NEEDED_MIDS; k++)
            if (lt[k] && rt[k])
            begin
                cnt++;
                sum += (lcol[k] + rcol[k]) / 2;
            end
        res = '0;
        if (cnt >= NEEDED_MIDS)
        begin
            v = NEEDED_MIDS * MID - sum;
            res.found = 1'b1;
            res.steering_milli = v[11:0];
        end
        return res;
    endfunction

    // one beat; start stays high across back-to-back beats
    task automatic send_word(input logic [31:0] px, input logic last);
        start <= 1'b1;
        beat <= '{pixel_bits: px, frame_end: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (load_ptr < STORE_WORDS)
        begin
            frame_mem[load_ptr] = px;
            load_ptr++;
        end
        if (last)
        begin
            pending_results.push_back(track_lanes());
            load_ptr = 0;
        end
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_POINT_COUNT:      points_reg = val & 8'h7F;
            CFG_SEARCH_RANGE:     range_reg = val & 8'hFF;
            CFG_ROW_STEP:         step_reg = val & 8'h1F;
            CFG_SMOOTH_LIMIT:     smooth_reg = val & 16'hFFFF;
            CFG_COLUMN_THRESHOLD: thresh_reg = val & 8'h7F;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_all(input int pc, input int sr, input int rs, input int sl, input int th);
        go_idle();
        write_reg(CFG_POINT_COUNT, pc);
        write_reg(CFG_SEARCH_RANGE, sr);
        write_reg(CFG_ROW_STEP, rs);
        write_reg(CFG_SMOOTH_LIMIT, sl);
        write_reg(CFG_COLUMN_THRESHOLD, th);
    endtask

    // two drifting lanes with jitter, gaps and sparse noise; extra words overrun the store
    task automatic send_lane_frame(input int extra);
        int lb, rb, sl, sr, jit, gaps, lc, rc, wl, wr;
        bit noisy;
        logic [31:0] row_buf [ROW_WORDS];
        lb = $urandom_range(150, 360);
        rb = $urandom_range(400, 610);
        sl = $urandom_range(0, 128) - 64;
        sr = $urandom_range(0, 128) - 64;
        jit = $urandom_range(0, 4);
        gaps = $urandom_range(0, 30);
        noisy = $urandom_range(0, 1);
        for (int r = 0; r < HEIGHT; r++)
        begin
            for (int w = 0; w < ROW_WORDS; w++)
                row_buf[w] = noisy ? ($urandom & $urandom & $urandom & $urandom) : 32'h0;
            lc = lb + sl * (HEIGHT - 1 - r) / 64 + $urandom_range(0, jit);
            rc = rb + sr * (HEIGHT - 1 - r) / 64 + $urandom_range(0, jit);
            wl = $urandom_range(1, 6);
            wr = $urandom_range(1, 6);
            if ($urandom_range(0, 99) >= gaps)
                for (int c = lc; c < lc + wl; c++)
                    if (c >= 0 && c < WIDTH)
                        row_buf[c / 32][c % 32] = 1'b1;
            if ($urandom_range(0, 99) >= gaps)
                for (int c = rc; c < rc + wr; c++)
                    if (c >= 0 && c < WIDTH)
                        row_buf[c / 32][c % 32] = 1'b1;
            for (int w = 0; w < ROW_WORDS; w++)
                send_word(row_buf[w], extra == 0 && r == HEIGHT - 1 && w == ROW_WORDS - 1);
        end
        for (int i = 0; i < extra; i++)
            send_word($urandom, i == extra - 1);
    endtask

    task automatic send_short_frame(input int len);
        logic [31:0] px;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 3))
                0: px = 32'h0;
                1: px = 32'hFFFF_FFFF;
                default: px = $urandom;
            endcase
            send_word(px, i == len - 1);
        end
    endtask

    task automatic test_default_frame();
        gap_pct = 0;
        send_short_frame(ROW_WORDS);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0, 1'b1);
    endtask

    // fills the whole store with a lane image, so it also runs first
    task automatic test_store_overflow();
        gap_pct = 67;
        send_lane_frame(12);
    endtask

    task automatic test_register_extremes();
        gap_pct = 10;
        set_all(3, 1, 1, 0, 0);
        send_word(32'h8000_0001, 1'b1);
        set_all(64, 255, 16, 65535, 64);
        send_word(32'h0, 1'b1);
        set_all(127, 0, 31, 1, 127);
        send_word($urandom, 1'b1);
        set_all(0, 255, 0, 65535, 0);
        send_word($urandom, 1'b1);
        set_all(2, 128, 31, 100, 5);
        send_word($urandom, 1'b1);
        set_all(64, 255, 31, 0, 19);
        send_word($urandom, 1'b1);
    endtask

    task automatic test_random_frames();
        int modes [3] = '{0, 67, 10};
        for (int i = 0; i < 90; i++)
        begin
            if (i % 10 == 0)
            begin
                set_all($urandom_range(3, 64), $urandom_range(1, 255), $urandom_range(1, 16),
                        $urandom_range(0, 400), $urandom_range(0, 40));
                gap_pct = modes[(i / 10) % 3];
            end
            send_short_frame($urandom_range(1, 40));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b steering=%0d",
                         $time, result.found, result.steering_milli);
                errors++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (result.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, result.found);
                    errors++;
                end
                if (result.steering_milli !== want.steering_milli)
                begin
                    $display("%0t: steering expected %0d actual %0d",
                             $time, want.steering_milli, result.steering_milli);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_store_overflow();
        test_default_frame();
        test_register_extremes();
        test_random_frames();
        go_idle();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
